// ===== design/acpt_pkg.sv =====
// Shared constants and word types of the AABB contact pair tracker.
package acpt_pkg;

    localparam int ID_BITS    = 8;
    localparam int COORD_BITS = 16;
    localparam int SIZE_BITS  = COORD_BITS - 1;
    localparam int ROWS       = 1 << ID_BITS;

    typedef logic [ID_BITS-1:0] t_id;
    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [SIZE_BITS-1:0] t_size;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } t_contact_event;

    typedef struct packed {
        t_id    first_id;
        t_id    second_id;
        t_coord first_cx;
        t_coord first_cy;
        t_size  first_w;
        t_size  first_h;
        t_coord second_cx;
        t_coord second_cy;
        t_size  second_w;
        t_size  second_h;
        logic   first_dying;
        logic   second_dying;
    } t_pair_word;

    typedef struct packed {
        t_contact_event contact_event;
        logic           boxes_overlap;
    } t_result_word;

endpackage

// ===== design/aabb_contact_pair_tracker.sv =====
// Top level of the AABB contact pair tracker with its contact bit memory.
// An accepted pair word passes the stage-1 register, then the output register.
// Throughput: one pair word per cycle unless the output stalls, set by the single
// read-modify-write of one contact row per pair, with same-row forwarding between
// back-to-back words. Reset clears all row valid flags at once; contacts read as zero.
module aabb_contact_pair_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  acpt_pkg::t_pair_word  i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output acpt_pkg::t_result_word o_out_word
);
    import acpt_pkg::*;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int SUM_BITS  = SIZE_BITS + 1;

    typedef logic [ROWS-1:0] t_row;

    function automatic logic axis_fit(input logic [DIFF_BITS-1:0] diff,
                                      input logic [SUM_BITS-1:0] sum);
        logic [DIFF_BITS-1:0] mag;
        mag = diff[DIFF_BITS-1] ? (~diff + 1'b1) : diff;
        return {mag[DIFF_BITS-2:0], 1'b0} <= {1'b0, sum};
    endfunction

    t_row mem [ROWS];
    t_row r_rd_row;
    logic r_rd_vld;
    logic [ROWS-1:0] r_row_valid;

    logic                 r_s1_valid;
    t_id                  r_s1_a;
    t_id                  r_s1_b;
    logic [DIFF_BITS-1:0] r_s1_dx;
    logic [DIFF_BITS-1:0] r_s1_dy;
    logic [SUM_BITS-1:0]  r_s1_wsum;
    logic [SUM_BITS-1:0]  r_s1_hsum;
    logic                 r_s1_dying;
    logic                 r_s1_hit;
    t_row                 r_hit_row;

    logic         r_out_valid;
    t_result_word r_out_word;

    logic                 in_acc;
    logic                 s1_move;
    logic [DIFF_BITS-1:0] n_dx;
    logic [DIFF_BITS-1:0] n_dy;
    logic [SUM_BITS-1:0]  n_wsum;
    logic [SUM_BITS-1:0]  n_hsum;
    logic                 n_hit;

    logic           s1_ov;
    logic           s1_same;
    logic           s1_prev;
    logic           s1_bit;
    t_row           s1_row;
    t_row           s1_wr_row;
    t_contact_event s1_ev;
    logic           wr_en;

    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign n_dx = {i_in_word.second_cx[COORD_BITS-1], i_in_word.second_cx}
                - {i_in_word.first_cx[COORD_BITS-1], i_in_word.first_cx};
    assign n_dy = {i_in_word.second_cy[COORD_BITS-1], i_in_word.second_cy}
                - {i_in_word.first_cy[COORD_BITS-1], i_in_word.first_cy};
    assign n_wsum = {1'b0, i_in_word.first_w} + {1'b0, i_in_word.second_w};
    assign n_hsum = {1'b0, i_in_word.first_h} + {1'b0, i_in_word.second_h};
    assign n_hit  = wr_en && (r_s1_a == i_in_word.first_id);

    assign s1_ov   = axis_fit(r_s1_dx, r_s1_wsum) && axis_fit(r_s1_dy, r_s1_hsum);
    assign s1_same = (r_s1_a == r_s1_b);
    assign s1_row  = r_s1_hit ? r_hit_row : (r_rd_vld ? r_rd_row : '0);
    assign s1_prev = s1_row[r_s1_b];
    assign wr_en   = s1_move && !s1_same;

    always_comb begin
        s1_ev  = EV_NONE;
        s1_bit = s1_prev;
        if (!s1_same) begin
            priority if (s1_ov && s1_prev && r_s1_dying) begin
                s1_ev  = EV_EXIT;
                s1_bit = 1'b0;
            end else if (s1_ov && s1_prev) begin
                s1_ev = EV_STAY;
            end else if (s1_ov && !r_s1_dying) begin
                s1_ev  = EV_ENTER;
                s1_bit = 1'b1;
            end else if (!s1_ov && s1_prev) begin
                s1_ev  = EV_EXIT;
                s1_bit = 1'b0;
            end else begin
                s1_ev = EV_NONE;
            end
        end
        s1_wr_row         = s1_row;
        s1_wr_row[r_s1_b] = s1_bit;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1_a] <= s1_wr_row;
        end
        if (in_acc) begin
            r_rd_row <= mem[i_in_word.first_id];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_hit    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_valid[r_s1_a] <= 1'b1;
            end
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_s1_hit   <= n_hit;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
                r_s1_hit   <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rd_vld   <= r_row_valid[i_in_word.first_id];
            r_s1_a     <= i_in_word.first_id;
            r_s1_b     <= i_in_word.second_id;
            r_s1_dx    <= n_dx;
            r_s1_dy    <= n_dy;
            r_s1_wsum  <= n_wsum;
            r_s1_hsum  <= n_hsum;
            r_s1_dying <= i_in_word.first_dying | i_in_word.second_dying;
            r_hit_row  <= s1_wr_row;
        end
        if (s1_move) begin
            r_out_word.contact_event <= s1_ev;
            r_out_word.boxes_overlap <= s1_ov;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef NO_ASSERTIONS
    a_stall_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s1_valid |-> !o_in_stall)
        else $error("Input stalled with an empty pipeline stage.");

    a_enter_overlaps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.contact_event == EV_ENTER ||
                         o_out_word.contact_event == EV_STAY))
        |-> o_out_word.boxes_overlap)
        else $error("Enter or stay reported without overlap.");

    a_hit_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_hit |-> r_s1_valid)
        else $error("Forwarded row held without a word in the stage.");

    a_write_marks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_row_valid[$past(r_s1_a)])
        else $error("Written contact row not marked valid.");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the AABB contact pair tracker, with its contact event scoreboard.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acpt_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;

    class contact_scoreboard;
        bit           contact [ROWS*ROWS];
        t_result_word expected_q [$];
        int           errors = 0;

        function bit axis_hit(t_coord c1, t_coord c2, t_size s1, t_size s2);
            longint d;
            d = longint'(c2) - longint'(c1);
            if (d < 0) begin
                d = -d;
            end
            return (2 * d) <= (longint'(s1) + longint'(s2));
        endfunction

        function void note_pair(t_pair_word w);
            bit             ov;
            bit             dying;
            bit             prev;
            int             idx;
            t_contact_event ev;
            t_result_word   r;
            ov = axis_hit(w.first_cx, w.second_cx, w.first_w, w.second_w)
                 && axis_hit(w.first_cy, w.second_cy, w.first_h, w.second_h);
            dying = w.first_dying | w.second_dying;
            ev = EV_NONE;
            if (w.first_id != w.second_id) begin
                idx = int'({w.first_id, w.second_id});
                prev = contact[idx];
                if (ov) begin
                    if (prev && dying) begin
                        ev = EV_EXIT;
                        contact[idx] = 1'b0;
                    end else if (prev) begin
                        ev = EV_STAY;
                    end else if (!dying) begin
                        ev = EV_ENTER;
                        contact[idx] = 1'b1;
                    end
                end else if (prev) begin
                    ev = EV_EXIT;
                    contact[idx] = 1'b0;
                end
            end
            r.contact_event = ev;
            r.boxes_overlap = ov;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_result_word got);
            t_result_word want;
            if (expected_q.size() == 0) begin
                $error("result word with no pair pending: contact_event %0d, boxes_overlap %0d",
                       got.contact_event, got.boxes_overlap);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.contact_event !== want.contact_event) begin
                $error("contact_event: expected %0d, actual %0d",
                       want.contact_event, got.contact_event);
                errors++;
            end
            if (got.boxes_overlap !== want.boxes_overlap) begin
                $error("boxes_overlap: expected %0d, actual %0d",
                       want.boxes_overlap, got.boxes_overlap);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         pair_valid = 1'b0;
    logic         pair_stall;
    t_pair_word   pair_word = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    t_result_word result_word;

    contact_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    aabb_contact_pair_tracker dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (pair_valid),
        .o_in_stall  (pair_stall),
        .i_in_word   (pair_word),
        .o_out_valid (result_valid),
        .i_out_stall (result_stall),
        .o_out_word  (result_word)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (pair_valid && !pair_stall) begin
                sb.note_pair(pair_word);
            end
            if (result_valid && !result_stall) begin
                sb.check_result(result_word);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (pair_valid && !pair_stall) || (result_valid && !result_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_pair_word pair_of(int a, int b, int cx1, int cy1, int w1, int h1,
                                           int cx2, int cy2, int w2, int h2, bit d1, bit d2);
        t_pair_word w;
        w.first_id     = t_id'(a);
        w.second_id    = t_id'(b);
        w.first_cx     = t_coord'(cx1);
        w.first_cy     = t_coord'(cy1);
        w.first_w      = t_size'(w1);
        w.first_h      = t_size'(h1);
        w.second_cx    = t_coord'(cx2);
        w.second_cy    = t_coord'(cy2);
        w.second_w     = t_size'(w2);
        w.second_h     = t_size'(h2);
        w.first_dying  = d1;
        w.second_dying = d2;
        return w;
    endfunction

    function automatic int pick_id();
        if ($urandom_range(99) < 80) begin
            return int'($urandom_range(7));
        end
        return int'($urandom_range(255));
    endfunction

    task automatic send_pair(input t_pair_word w);
        while ($urandom_range(99) < tx_idle_pct) begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair_valid <= 1'b1;
        pair_word <= w;
        @(posedge clk);
        while (pair_stall) begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        pair_valid <= 1'b0;
        do begin
            @(negedge clk);
        end while (sb.pending() != 0);
        @(posedge clk);
    endtask

    task automatic send_noise();
        t_pair_word w;
        w.first_id     = t_id'($urandom);
        w.second_id    = t_id'($urandom);
        w.first_cx     = t_coord'($urandom);
        w.first_cy     = t_coord'($urandom);
        w.first_w      = t_size'($urandom);
        w.first_h      = t_size'($urandom);
        w.second_cx    = t_coord'($urandom);
        w.second_cy    = t_coord'($urandom);
        w.second_w     = t_size'($urandom);
        w.second_h     = t_size'($urandom);
        w.first_dying  = 1'($urandom_range(1));
        w.second_dying = 1'($urandom_range(1));
        send_pair(w);
    endtask

    // A pair hovers around contact for a few words, so enter, stay and exit follow each other.
    task automatic send_episode();
        int a, b, w1, h1, w2, h2, bx, by, len, reach_x, reach_y, ox, oy;
        bit d1, d2;
        a = pick_id();
        b = pick_id();
        w1 = int'($urandom_range(400));
        h1 = int'($urandom_range(400));
        w2 = int'($urandom_range(400));
        h2 = int'($urandom_range(400));
        bx = int'($urandom_range(65535)) - 32768;
        by = int'($urandom_range(65535)) - 32768;
        len = int'($urandom_range(2, 8));
        reach_x = (w1 + w2) / 2 + 1;
        reach_y = (h1 + h2) / 2 + 1;
        for (int i = 0; i < len; i++) begin
            ox = int'($urandom_range(2 * reach_x + 40)) - (reach_x + 20);
            oy = int'($urandom_range(2 * reach_y + 40)) - (reach_y + 20);
            d1 = ($urandom_range(99) < 6);
            d2 = ($urandom_range(99) < 6);
            if (i == len - 1 && $urandom_range(3) == 0) begin
                d1 = 1'b1;
            end
            send_pair(pair_of(a, b, bx, by, w1, h1, bx + ox, by + oy, w2, h2, d1, d2));
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15) begin
                send_noise();
            end else begin
                send_episode();
            end
        end
    endtask

    task automatic run_directed();
        send_pair(pair_of(0, 255, -32768, -32768, 32767, 32767,
                          32767, 32767, 32767, 32767, 0, 0));
        send_pair(pair_of(0, 255, 0, 0, 32767, 32767, 0, 0, 32767, 32767, 0, 0));
        send_pair(pair_of(0, 255, -16384, 0, 32767, 32767, 16383, 0, 32767, 32767, 0, 0));
        send_pair(pair_of(0, 255, -16384, 0, 32767, 32767, 16384, 0, 32767, 32767, 0, 0));
        send_pair(pair_of(255, 0, -32768, 32767, 0, 0, -32768, 32767, 0, 0, 0, 0));
        send_pair(pair_of(255, 0, -32768, 32767, 0, 0, -32767, 32767, 0, 0, 0, 0));
        send_pair(pair_of(3, 4, 0, 0, 10, 4, 10, 0, 10, 4, 0, 0));
        send_pair(pair_of(4, 3, 0, 0, 10, 4, 10, 0, 10, 4, 0, 0));
        send_pair(pair_of(3, 4, 0, 0, 10, 4, 11, 0, 10, 4, 0, 0));
        send_pair(pair_of(4, 3, 0, 0, 10, 4, 5, 1, 10, 4, 0, 0));
        send_pair(pair_of(4, 3, 0, 0, 10, 4, 5, 1, 10, 4, 1, 0));
        send_pair(pair_of(4, 3, 0, 0, 10, 4, 5, 1, 10, 4, 0, 1));
        send_pair(pair_of(4, 3, 0, 0, 10, 4, 5, 1, 10, 4, 0, 0));
        send_pair(pair_of(4, 3, 0, 0, 10, 4, 5, 1, 10, 4, 0, 1));
        send_pair(pair_of(9, 9, 7, 7, 20, 20, 7, 7, 20, 20, 0, 0));
        send_pair(pair_of(9, 9, 7, 7, 20, 20, 900, 7, 20, 20, 0, 0));
        send_pair(pair_of(10, 11, 0, 0, 2, 2, 100, 100, 2, 2, 1, 1));
        send_pair(pair_of(10, 11, 0, 0, 30, 8, 10, 9, 30, 8, 0, 0));
        send_pair(pair_of(200, 100, 0, 32767, 32767, 32767, 0, -32768, 32767, 32767, 0, 0));
        send_pair(pair_of(200, 100, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 0, 0));
        send_pair(pair_of(200, 100, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 0, 0));
        send_pair(pair_of(200, 100, 32767, 32767, 32767, 32767,
                          32767, 32767, 32767, 32767, 1, 1));
    endtask

    initial begin
        sb = new();
        tx_idle_pct = 11;
        rx_idle_pct = 59;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        run_random(480);
        wait_drained();
        tx_idle_pct = 59;
        rx_idle_pct = 11;
        run_random(480);
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(490);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0) begin
            $error("%0d expected result words never arrived", sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/acpt_pkg.sv
design/aabb_contact_pair_tracker.sv
tb/tb.sv
